@@ hdl/uld_pkg.sv @@
`timescale 1ns / 1ps

package uld_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 21;
    localparam int HOLD_N  = 4;
    localparam int HIDX_W  = 2;
    localparam int HCNT_W  = 3;
    localparam int PEND_W  = 2;

    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;

    localparam logic [PEND_W-1:0] NEED_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] NEED_ONE   = 2'd1;
    localparam logic [PEND_W-1:0] NEED_TWO   = 2'd2;
    localparam logic [PEND_W-1:0] NEED_THREE = 2'd3;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef byte_t hold_t [HOLD_N];

endpackage

@@ hdl/utf8_lenient_decoder.sv @@
`timescale 1ns / 1ps

// Lenient UTF-8 decoder. Bytes enter with a stream_end flag; each result
// carries a 21-bit code point, or a raw byte (is_raw = 1) when a sequence
// fails (a continuation without its top bit) or is cut short by stream_end.
// A lead byte that opens a sequence gives no result unless stream_end cuts it
// short; run_last marks the final result of each input byte. Rate: a byte is
// taken every cycle while the output keeps up. A byte that causes n results
// holds the result burst register until all n are taken, since that register
// drains one result per cycle while out_stall is low; one more byte can wait
// in the input register meanwhile. A byte passes through the input register
// and then the result burst register before its first result appears.
module utf8_lenient_decoder
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [uld_pkg::BYTE_W-1:0] data_byte,
    input  logic                      stream_end,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [uld_pkg::CODE_W-1:0] code_value,
    output logic                      is_raw,
    output logic                      run_last
);
    import uld_pkg::*;

    // input register
    logic              in_full_reg;
    byte_t             in_byte_reg;
    logic              in_end_reg;

    // decoder state
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [CODE_W-1:0] acc_reg, acc_next;
    logic              seq_ok_reg, seq_ok_next;
    hold_t             held_reg, held_next;
    logic [HCNT_W-1:0] hcnt_reg, hcnt_next;

    // result burst register
    logic [HCNT_W-1:0] buf_cnt_reg, buf_cnt_next;
    logic [HIDX_W-1:0] buf_idx_reg;
    logic              buf_raw_reg, buf_raw_next;
    logic [CODE_W-1:0] buf_code_reg, buf_code_next;
    hold_t             buf_byte_reg;

    logic              out_take;
    logic              out_done;
    logic              buf_free;
    logic              proc;
    logic              in_take;

    assign out_valid  = (buf_cnt_reg != '0);
    assign out_take   = out_valid && !out_stall;
    // the burst ends when its final result is taken
    assign out_done   = out_take && ({1'b0, buf_idx_reg} == (buf_cnt_reg - 3'd1));
    assign buf_free   = !out_valid || out_done;
    assign proc       = in_full_reg && buf_free;
    assign in_stall   = in_full_reg && !proc;
    assign in_take    = in_valid && !in_stall;

    assign is_raw     = buf_raw_reg;
    assign run_last   = ({1'b0, buf_idx_reg} == (buf_cnt_reg - 3'd1));
    assign code_value = buf_raw_reg ? {{(CODE_W-BYTE_W){1'b0}}, buf_byte_reg[buf_idx_reg]}
                                    : buf_code_reg;

    // Decode one byte against the open sequence. A flush replays the held
    // bytes raw; held_next already has the current byte in place.
    always_comb
    begin
        logic [PEND_W-1:0] pend_dec;
        logic              ok_dec;
        logic              flush;
        byte_t             b;

        b             = in_byte_reg;
        pend_next     = pend_reg;
        acc_next      = acc_reg;
        seq_ok_next   = seq_ok_reg;
        held_next     = held_reg;
        hcnt_next     = hcnt_reg;
        buf_cnt_next  = '0;
        buf_raw_next  = 1'b0;
        buf_code_next = {{(CODE_W-BYTE_W){1'b0}}, b};
        pend_dec      = pend_reg - NEED_ONE;
        ok_dec        = seq_ok_reg && b[BYTE_W-1];
        flush         = 1'b0;

        if (pend_reg == NEED_NONE)
        begin
            held_next[0] = b;
            hcnt_next    = 3'd1;
            seq_ok_next  = 1'b1;
            if ((b & LEAD4_MASK) == LEAD4_MASK)
            begin
                pend_next = NEED_THREE;
                acc_next  = {{(CODE_W-BYTE_W){1'b0}}, b & LEAD4_BITS};
            end
            else if ((b & LEAD3_MASK) == LEAD3_MASK)
            begin
                pend_next = NEED_TWO;
                acc_next  = {{(CODE_W-BYTE_W){1'b0}}, b & LEAD3_BITS};
            end
            else if ((b & LEAD2_MASK) == LEAD2_MASK)
            begin
                pend_next = NEED_ONE;
                acc_next  = {{(CODE_W-BYTE_W){1'b0}}, b & LEAD2_BITS};
            end
            else
            begin
                // pass through, sequence stays closed
                held_next    = held_reg;
                hcnt_next    = '0;
                seq_ok_next  = seq_ok_reg;
                buf_cnt_next = 3'd1;
            end
            if (pend_next != NEED_NONE && in_end_reg)
                flush = 1'b1;
        end
        else
        begin
            held_next[hcnt_reg[HIDX_W-1:0]] = b;
            hcnt_next   = hcnt_reg + 3'd1;
            seq_ok_next = ok_dec;
            if (ok_dec)
                acc_next = {acc_reg[CODE_W-7:0], b[5:0] & CONT_BITS[5:0]};
            pend_next = pend_dec;
            if (pend_dec == NEED_NONE)
            begin
                if (ok_dec)
                begin
                    buf_cnt_next  = 3'd1;
                    buf_code_next = {acc_reg[CODE_W-7:0], b[5:0] & CONT_BITS[5:0]};
                    pend_next     = NEED_NONE;
                    acc_next      = '0;
                    seq_ok_next   = 1'b1;
                    hcnt_next     = '0;
                end
                else
                    flush = 1'b1;
            end
            else if (in_end_reg)
                flush = 1'b1;
        end

        if (flush)
        begin
            buf_cnt_next = hcnt_next;
            buf_raw_next = 1'b1;
            pend_next    = NEED_NONE;
            acc_next     = '0;
            seq_ok_next  = 1'b1;
            hcnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            pend_reg    <= NEED_NONE;
            acc_reg     <= '0;
            seq_ok_reg  <= 1'b1;
            hcnt_reg    <= '0;
            buf_cnt_reg <= '0;
            buf_idx_reg <= '0;
            buf_raw_reg <= 1'b0;
        end
        else
        begin
            // hold the waiting byte until the decoder takes it
            if (in_take)
                in_full_reg <= 1'b1;
            else if (proc)
                in_full_reg <= 1'b0;

            if (proc)
            begin
                pend_reg    <= pend_next;
                acc_reg     <= acc_next;
                seq_ok_reg  <= seq_ok_next;
                hcnt_reg    <= hcnt_next;
                buf_cnt_reg <= buf_cnt_next;
                buf_idx_reg <= '0;
                buf_raw_reg <= buf_raw_next;
            end
            else if (out_done)
            begin
                buf_cnt_reg <= '0;
                buf_idx_reg <= '0;
            end
            else if (out_take)
                buf_idx_reg <= buf_idx_reg + 2'd1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= data_byte;
            in_end_reg  <= stream_end;
        end
        if (proc)
        begin
            held_reg     <= held_next;
            buf_byte_reg <= held_next;
            buf_code_reg <= buf_code_next;
        end
    end

    // a decoded or passed-through value is always a burst of one
    a_single_when_cooked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_raw) |-> run_last)
        else $error("non-raw result is not alone in its burst");

    a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, buf_idx_reg} < buf_cnt_reg))
        else $error("burst index beyond burst length");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == NEED_NONE) |-> (hcnt_reg == '0))
        else $error("held bytes left in a closed sequence");

    a_open_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != NEED_NONE) |->
            (hcnt_reg != '0 && ({1'b0, hcnt_reg} + {2'b00, pend_reg}) <= 4'd4))
        else $error("open sequence exceeds four bytes");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !proc) |=> in_full_reg)
        else $error("waiting byte dropped");

endmodule

@@ dv/utf8_lenient_decoder_tb.sv @@
`timescale 1ns / 1ps

// Testbench for the lenient UTF-8 decoder. The stimulus is a stream of byte
// requests, each with its end-of-stream flag. A predictor runs beside the
// block and expands every accepted request into the code points or raw bytes
// it should cause. Each accepted result is checked field by field against
// the oldest prediction. Test tasks run in turn: first directed cases, then
// random phases under changing idle patterns, and one long output hold-off.
module utf8_lenient_decoder_tb;

    import uld_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES    = 60;     // length of the long output hold-off
    localparam int SETTLE_CYCLES  = 4;      // settle margin after the last result

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              raw;
        logic              last;
    } code_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  data_byte = '0;
    logic               stream_end = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CODE_W-1:0]  code_value;
    logic               is_raw;
    logic               run_last;

    // Decoder state as the predictor sees it.
    logic [PEND_W-1:0]  dec_pend;
    logic [CODE_W-1:0]  dec_acc;
    logic               dec_ok;
    byte_t              dec_held [HOLD_N];
    logic [HCNT_W-1:0]  dec_held_n;
    int                 dec_burst;

    code_rec_t          code_points_due [$];
    code_rec_t          want;

    // Idle percentages for the two sides, set per test phase.
    int                 send_pct = 0;
    int                 recv_pct = 0;
    bit                 hold_request = 1'b0;
    int                 hold_left = 0;

    int                 errors = 0;
    int                 bytes_sent = 0;
    int                 results_seen = 0;
    int                 raw_seen = 0;
    int                 backpressure_cycles = 0;
    int                 quiet_cycles = 0;

    utf8_lenient_decoder DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_value (code_value),
        .is_raw     (is_raw),
        .run_last   (run_last)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void close_seq();
        dec_pend   = NEED_NONE;
        dec_acc    = '0;
        dec_ok     = 1'b1;
        dec_held_n = '0;
    endfunction

    function automatic void push_code(logic [CODE_W-1:0] code, logic raw);
        code_rec_t rec;
        rec.code = code;
        rec.raw  = raw;
        rec.last = 1'b0;
        code_points_due = {code_points_due, rec};
        dec_burst++;
    endfunction

    // Emit every held byte raw, in arrival order, and close the sequence.
    function automatic void flush_held();
        for (int i = 0; i < dec_held_n && i < HOLD_N; i++)
        begin
            push_code({{(CODE_W-BYTE_W){1'b0}}, dec_held[i]}, 1'b1);
        end
        close_seq();
    endfunction

    // Expand one accepted byte into its expected results.
    function automatic void decode_byte(byte_t b, logic fin);
        logic [PEND_W-1:0] need;
        logic [CODE_W-1:0] lead;
        need = NEED_NONE;
        lead = '0;
        dec_burst = 0;
        if (dec_pend == NEED_NONE)
        begin
            if ((b & LEAD4_MASK) == LEAD4_MASK)
            begin
                need = NEED_THREE;
                lead = CODE_W'(b & LEAD4_BITS);
            end
            else if ((b & LEAD3_MASK) == LEAD3_MASK)
            begin
                need = NEED_TWO;
                lead = CODE_W'(b & LEAD3_BITS);
            end
            else if ((b & LEAD2_MASK) == LEAD2_MASK)
            begin
                need = NEED_ONE;
                lead = CODE_W'(b & LEAD2_BITS);
            end
            else
            begin
                push_code({{(CODE_W-BYTE_W){1'b0}}, b}, 1'b0);
            end
            if (need != NEED_NONE)
            begin
                dec_held[0] = b;
                dec_held_n  = 3'd1;
                dec_acc     = lead;
                dec_ok      = 1'b1;
                dec_pend    = need;
                if (fin)
                    flush_held();
            end
        end
        else
        begin
            dec_held[dec_held_n[HIDX_W-1:0]] = b;
            dec_held_n = dec_held_n + 3'd1;
            if ((b & CONT_MASK) != CONT_MASK)
                dec_ok = 1'b0;
            if (dec_ok)
                dec_acc = {dec_acc[CODE_W-7:0], b[5:0]};
            dec_pend = dec_pend - 2'd1;
            if (dec_pend == NEED_NONE)
            begin
                if (dec_ok)
                begin
                    push_code(dec_acc, 1'b0);
                    close_seq();
                end
                else
                begin
                    flush_held();
                end
            end
            else if (fin)
            begin
                flush_held();
            end
        end
        if (dec_burst > 0)
            code_points_due[code_points_due.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer one byte request, hold it until taken, then predict
    // ------------------------------------------------------------------

    task automatic send_byte(input byte_t b, input logic fin);
        // Drop valid for a random number of cycles before the request.
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        stream_end <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (code_points_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off when a test asks for one
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest one due
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (code_points_due.size() == 0)
            begin
                $display("%0t: unexpected result code=%h raw=%b last=%b",
                         $time, code_value, is_raw, run_last);
                errors++;
            end
            else
            begin
                want = code_points_due.pop_front();
                if (want.raw)
                    raw_seen++;
                if (code_value !== want.code)
                begin
                    $display("%0t: code_value expected %h actual %h",
                             $time, want.code, code_value);
                    errors++;
                end
                if (is_raw !== want.raw)
                begin
                    $display("%0t: is_raw expected %b actual %b",
                             $time, want.raw, is_raw);
                    errors++;
                end
                if (run_last !== want.last)
                begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, want.last, run_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    always @(posedge clk)
    begin
        if (in_valid && in_stall)
            backpressure_cycles++;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles, %0d results still due",
                     $time, quiet_cycles, code_points_due.size());
            $display("[utf8_lenient_decoder] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every lead class, and each special case by hand.
    task automatic test_directed();
        send_pct = 0;
        recv_pct = 0;
        // plain passthrough at both ends of the ASCII range
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        // stray continuation bytes pass through, one closing a stream
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b1);
        // two-byte sequence
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        // three-byte sequence
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        // four-byte sequence
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // out-of-range lead gives the largest code value
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // bad continuation: keep collecting, then flush all three raw
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h82, 1'b0);
        // lead byte cut off by end of stream
        send_byte(8'hC3, 1'b1);
        // sequence cut off after one continuation
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b1);
        // completion on the final byte counts as normal
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b1);
        wait_drained();
    endtask

    // Mostly well-formed sequences with random content, some broken or cut
    // short, and the rest single noise bytes.
    task automatic send_random_run();
        int    ncont;
        int    bad_at;
        int    cut_at;
        byte_t b;
        logic  fin;
        if ($urandom_range(9) < 7)
        begin
            ncont  = $urandom_range(1, 3);
            bad_at = ($urandom_range(3) == 0) ? $urandom_range(1, ncont) : 0;
            cut_at = ($urandom_range(4) == 0) ? $urandom_range(0, ncont - 1) : -1;
            case (ncont)
                1:       b = byte_t'($urandom_range(LEAD2_MASK, LEAD3_MASK - 1));
                2:       b = byte_t'($urandom_range(LEAD3_MASK, LEAD4_MASK - 1));
                default: b = byte_t'($urandom_range(LEAD4_MASK, 8'hFF));
            endcase
            send_byte(b, cut_at == 0);
            for (int i = 1; i <= ncont && cut_at != i - 1; i++)
            begin
                if (i == bad_at)
                    b = $urandom_range(1) ? byte_t'($urandom_range(0, 8'h7F))
                                          : byte_t'($urandom_range(LEAD2_MASK, 8'hFF));
                else
                    b = byte_t'($urandom_range(CONT_MASK, LEAD2_MASK - 1));
                fin = (i == cut_at) || (i == ncont && $urandom_range(4) == 0);
                send_byte(b, fin);
            end
        end
        else
        begin
            send_byte(byte_t'($urandom_range(255)), $urandom_range(9) == 0);
        end
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        int stop_at;
        stop_at  = bytes_sent + count;
        send_pct = s_pct;
        recv_pct = r_pct;
        while (bytes_sent < stop_at)
            send_random_run();
        wait_drained();
    endtask

    // Hold the output off for a long stretch while requests keep coming, so
    // the block fills up and has to stall its input.
    task automatic test_backpressure();
        send_pct = 0;
        recv_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++)
            send_byte(byte_t'($urandom_range(0, 8'h7F)), 1'b0);
        for (int i = 0; i < 10; i++)
            send_random_run();
        wait_drained();
    endtask

    initial
    begin
        close_seq();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(120, 33, 50);
        test_random(120, 50, 33);
        test_backpressure();
        test_random(120, 0, 0);

        $display("Sent %0d bytes across directed, random and hold-off phases;",
                 bytes_sent);
        $display("input stalled %0d cycles, checked %0d results, %0d of them raw bytes.",
                 backpressure_cycles, results_seen, raw_seen);
        if (errors == 0 && code_points_due.size() == 0)
            $display("[utf8_lenient_decoder] OK");
        else
            $display("[utf8_lenient_decoder] ERROR");
        $finish;
    end

endmodule
